>>> src/dali_tx_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the DALI forward frame transmitter.
// No dependencies; used by the front, back and top-level files.
package dali_tx_pkg;

  // Kind of an input transaction, carried on s_axis_tuser
  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_SEND = 1'b1
  } req_e;

  // Result word, lowest bit first: line_level, busy_res, frame_done, rejected
  typedef struct packed {
    logic rejected;
    logic frame_done;
    logic busy_res;
    logic line_level;
  } tx_status_t;

  localparam int unsigned StatusW = $bits(tx_status_t);

  // Reset value of half_bit_ticks (one microsecond ticks)
  localparam logic [15:0] HalfBitTicksRst = 16'd416;

endpackage

>>> src/dali_tx_fifo.sv
`timescale 1ns / 1ps
// Small flip-flop queue between the front and back of the DALI transmitter.
// Self-contained; instantiated by dali_tx_front.
module dali_tx_fifo #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> src/dali_tx_front.sv
`timescale 1ns / 1ps
// Front end of the DALI transmitter: decodes input transactions and
// builds the frame word, then queues them. Uses dali_tx_pkg, dali_tx_fifo.
module dali_tx_front #(
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 pop_i,
  output logic                 head_valid_o,
  output dali_tx_pkg::req_e    head_kind_o,
  output logic [DATA_BITS-1:0] head_word_o
);

  localparam int unsigned EntryW = DATA_BITS + 1;

  logic                 full, empty;
  dali_tx_pkg::req_e    kind;
  logic [DATA_BITS-1:0] word;
  logic [EntryW-1:0]    entry_in, entry_out;

  // Address in the upper byte, command in the lower; trimmed or zero-padded
  // to the frame width. Ticks carry no word.
  assign kind     = dali_tx_pkg::req_e'(s_axis_tuser);
  assign word     = (kind == dali_tx_pkg::REQ_SEND)
                  ? DATA_BITS'({s_axis_tdata[7:0], s_axis_tdata[15:8]}) : '0;
  assign entry_in = {kind, word};

  dali_tx_fifo #(
    .WIDTH (EntryW),
    .DEPTH (2)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (entry_in),
    .full_o      (full),
    .pop_i       (pop_i),
    .empty_o     (empty),
    .head_o      (entry_out)
  );

  assign s_axis_tready = !full;
  assign head_valid_o  = !empty;
  assign head_kind_o   = dali_tx_pkg::req_e'(entry_out[EntryW-1]);
  assign head_word_o   = entry_out[DATA_BITS-1:0];

endmodule

>>> src/dali_tx_back.sv
`timescale 1ns / 1ps
// Back end of the DALI transmitter: Manchester frame sequencer and the
// result register. Uses dali_tx_pkg.
module dali_tx_back #(
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    head_valid_i,
  input  dali_tx_pkg::req_e       head_kind_i,
  input  logic [DATA_BITS-1:0]    head_word_i,
  output logic                    pop_o,
  input  logic [15:0]             half_bit_ticks_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output dali_tx_pkg::tx_status_t out_status_o
);

  localparam int unsigned TotalHalves = 2 * (1 + DATA_BITS);
  localparam int unsigned HalfW       = $clog2(TotalHalves);
  localparam logic [HalfW-1:0] LastHalf = HalfW'(TotalHalves - 1);

  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic [HalfW-1:0]     half_q, half_d;
  logic [15:0]          tick_q, tick_d;
  logic                 sending_q, sending_d;
  logic                 level_q, level_d;
  logic                 out_valid_q, out_valid_d;
  dali_tx_pkg::tx_status_t status_q, status_d;

  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic        done, rej;

  assign pop_o    = head_valid_i && (!out_valid_q || out_ready_i);
  assign limit    = (half_bit_ticks_i == '0) ? 16'd1 : half_bit_ticks_i;
  assign tick_inc = tick_q + 16'd1;

  always_comb begin
    shift_d   = shift_q;
    half_d    = half_q;
    tick_d    = tick_q;
    sending_d = sending_q;
    level_d   = level_q;
    done      = 1'b0;
    rej       = 1'b0;
    if (pop_o) begin
      if (head_kind_i == dali_tx_pkg::REQ_SEND) begin
        if (sending_q) begin
          rej = 1'b1;
        end else begin
          // first half of the start bit: line high
          shift_d   = head_word_i;
          half_d    = '0;
          tick_d    = '0;
          sending_d = 1'b1;
          level_d   = 1'b1;
        end
      end else if (sending_q) begin
        if (tick_inc >= limit) begin
          tick_d = '0;
          if (half_q == LastHalf) begin
            sending_d = 1'b0;
            half_d    = '0;
            level_d   = 1'b0;
            done      = 1'b1;
          end else begin
            half_d = half_q + HalfW'(1);
            if (!half_q[0]) begin
              // second half of a bit is the complement
              level_d = !level_q;
            end else begin
              // next data bit, MSB first
              level_d = shift_q[DATA_BITS-1];
              shift_d = {shift_q[DATA_BITS-2:0], 1'b0};
            end
          end
        end else begin
          tick_d = tick_inc;
        end
      end
    end
  end

  always_comb begin
    status_d            = status_q;
    status_d.line_level = level_d;
    status_d.busy_res   = sending_d;
    status_d.frame_done = done;
    status_d.rejected   = rej;
    out_valid_d         = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      half_q      <= '0;
      tick_q      <= '0;
      sending_q   <= 1'b0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      shift_q     <= shift_d;
      half_q      <= half_d;
      tick_q      <= tick_d;
      sending_q   <= sending_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;

endmodule

>>> src/dali_forward_frame_transmitter.sv
`timescale 1ns / 1ps
// DALI forward frame transmitter. Each input transaction is either a time
// tick or a send request; every one yields exactly one result transaction
// with the transmit line level, busy flag, frame-done and rejected flags.
// A send request starts a frame: start bit then DATA_BITS data bits, MSB
// first, Manchester coded for an inverting driver (1 = high/low, 0 =
// low/high, start bit as 1), each half-bit half_bit_ticks ticks long. A
// request while busy is rejected and leaves the frame alone. Throughput is
// one transaction per clock while neither side stalls; on acceptance the
// transaction enters the two-entry input queue, then moves into the
// sequencer's result register, where the result is presented and can be
// taken. Either side may stall independently: while a result waits the
// queue still takes two more input transactions before tready drops.
// half_bit_ticks may be written only while no transaction is in flight.
// Depends on dali_tx_pkg, dali_tx_front, dali_tx_back.
module dali_forward_frame_transmitter #(
  parameter int unsigned DATA_BITS = 16   // frame data bits, 8..24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: half_bit_ticks
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] address_byte, [15:8] command_byte
  input  logic        s_axis_tuser,   // [0] req_type (0 tick, 1 send)
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] line_level, [1] busy_res,
                                      // [2] frame_done, [3] rejected, [7:4] 0
);

  logic [15:0]             half_bit_ticks_q;
  logic                    head_valid;
  dali_tx_pkg::req_e       head_kind;
  logic [DATA_BITS-1:0]    head_word;
  logic                    pop;
  dali_tx_pkg::tx_status_t status;

  // Ticks per half-bit; zero behaves as one in the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_bit_ticks_q <= dali_tx_pkg::HalfBitTicksRst;
    end else if (cfg_we_i) begin
      half_bit_ticks_q <= cfg_wdata_i;
    end
  end

  // Front: decode and queue
  dali_tx_front #(
    .DATA_BITS (DATA_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop_i         (pop),
    .head_valid_o  (head_valid),
    .head_kind_o   (head_kind),
    .head_word_o   (head_word)
  );

  // Back: frame sequencer and result register
  dali_tx_back #(
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_kind_i      (head_kind),
    .head_word_i      (head_word),
    .pop_o            (pop),
    .half_bit_ticks_i (half_bit_ticks_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_status_o     (status)
  );

  assign m_axis_tdata = {(8 - dali_tx_pkg::StatusW)'(0), status};

endmodule

>>> src/dali_tx_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the DALI forward frame transmitter, bound to the
// top level. No package dependencies.
module dali_tx_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The frame end leaves the line low and the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1] && !m_axis_tdata[0])
    else $error("frame_done while busy or line high");

  // A rejection only happens while a frame is in progress
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[1] && !m_axis_tdata[2])
    else $error("rejected while idle");

  // Idle line rests low
  a_idle_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> !m_axis_tdata[0])
    else $error("line high while idle");

endmodule

bind dali_forward_frame_transmitter dali_tx_assert u_dali_tx_assert (.*);
